[design/spk_pkg.sv]
// Speck cipher package: shared types, codes, register map and variant table.
// No dependencies; every other design file but spk_ram refers to it by scoped names.
package spk_pkg;

  localparam int DATA_W            = 64;
  localparam int CFG_ADDR_W        = 6;
  localparam int MAX_WORD_BITS_DEF = 64;
  localparam int MAX_ROUNDS_DEF    = 34;

  // register indexes (paddr[5:3])
  localparam logic [2:0] REG_VARIANT = 3'd0;
  localparam logic [2:0] REG_KEY0    = 3'd1;
  localparam logic [2:0] REG_KEY1    = 3'd2;
  localparam logic [2:0] REG_KEY2    = 3'd3;
  localparam logic [2:0] REG_KEY3    = 3'd4;

  typedef enum logic {
    OP_ENC = 1'b0,
    OP_DEC = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_X_BIG = 2'd1,
    ST_Y_BIG = 2'd2
  } status_t;

  typedef struct packed {
    logic [6:0] bits;
    logic [2:0] words;
    logic [5:0] rounds;
    logic [3:0] ra;
    logic [1:0] rb;
  } vparam_t;

  // codes above 9 saturate to the 128/256 variant
  function automatic vparam_t variant_params(input logic [3:0] code);
    vparam_t p;
    case (code)
      4'd0:    p = '{7'd16, 3'd4, 6'd22, 4'd7, 2'd2};
      4'd1:    p = '{7'd24, 3'd3, 6'd22, 4'd8, 2'd3};
      4'd2:    p = '{7'd24, 3'd4, 6'd23, 4'd8, 2'd3};
      4'd3:    p = '{7'd32, 3'd3, 6'd26, 4'd8, 2'd3};
      4'd4:    p = '{7'd32, 3'd4, 6'd27, 4'd8, 2'd3};
      4'd5:    p = '{7'd48, 3'd2, 6'd28, 4'd8, 2'd3};
      4'd6:    p = '{7'd48, 3'd3, 6'd29, 4'd8, 2'd3};
      4'd7:    p = '{7'd64, 3'd2, 6'd32, 4'd8, 2'd3};
      4'd8:    p = '{7'd64, 3'd3, 6'd33, 4'd8, 2'd3};
      default: p = '{7'd64, 3'd4, 6'd34, 4'd8, 2'd3};
    endcase
    return p;
  endfunction

endpackage

[design/spk_ifs.sv]
// Valid/ready channel interfaces for the Speck cipher: block in, result out.
// Depends on spk_pkg for the data width.
interface spk_in_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [spk_pkg::DATA_W-1:0]  word_x;
  logic [spk_pkg::DATA_W-1:0]  word_y;

  modport source (output valid, action, word_x, word_y, input ready);
  modport sink   (input valid, action, word_x, word_y, output ready);
endinterface

interface spk_out_if;
  logic                        valid;
  logic                        ready;
  logic [spk_pkg::DATA_W-1:0]  out_x;
  logic [spk_pkg::DATA_W-1:0]  out_y;
  logic [1:0]                  status;

  modport source (output valid, out_x, out_y, status, input ready);
  modport sink   (input valid, out_x, out_y, status, output ready);
endinterface

[design/speck_block_cipher_top.sv]
// Speck block cipher top level: APB register file, sequencer, round-key RAM.
// Depends on spk_pkg, spk_ifs (channels), spk_ram and spk_round.
//
// Speck cipher for all ten block/key variants. Write the variant (offset 0x00)
// and key words 0..3 (offsets 0x08..0x20) over the APB port, then send beats
// of {action, word_x, word_y}; action 0 encrypts, 1 decrypts. Each result beat
// carries the two words and a status: 0 ok, 1 word_x has bits above the word
// size, 2 word_y does (words are then zero). Variant codes 10..15 behave as 9.
// A variant or key write marks the key schedule stale; the next accepted
// block first expands the key, one round key per cycle through the single
// round unit, R keys in all (R = 22..34, the variant's round count). A block
// then passes S_PREP, which fetches the first round key from the key RAM,
// S_RUN, R rounds at one per cycle on the shared round unit, and S_FIN, which
// hands the result to the output register once it is free. A size error goes
// from idle straight to S_FIN, skips the rounds and leaves a stale schedule
// for the next well-formed block to expand. The sequencer is back in idle as
// the result is loaded, so the next beat can be taken in the cycle after.
// The input is ready only while the sequencer is idle; the output register
// lets the next block start while the previous result waits to be taken.
module speck_block_cipher_top #(
  parameter int MAX_WORD_BITS = spk_pkg::MAX_WORD_BITS_DEF,
  parameter int MAX_ROUNDS    = spk_pkg::MAX_ROUNDS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  spk_in_if.sink                         in_ch,
  spk_out_if.source                      out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [spk_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [spk_pkg::DATA_W-1:0]     pwdata,
  output logic [spk_pkg::DATA_W-1:0]     prdata,
  output logic                           pready
);

  localparam int W  = MAX_WORD_BITS;
  localparam int AW = $clog2(MAX_ROUNDS);
  localparam int RW = $clog2(MAX_ROUNDS + 1);
  localparam int DW = spk_pkg::DATA_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXPAND,
    S_PREP,
    S_RUN,
    S_FIN
  } state_t;

  // ---------------- register file ----------------
  logic [3:0]    variant_r;
  logic [DW-1:0] key_r [4];
  logic          cfg_wr;
  logic          cfg_hit;
  logic [2:0]    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[5:3];
  assign cfg_wr  = psel & penable & pwrite;
  // writes beyond the key words are dropped and leave the schedule alone
  assign cfg_hit = cfg_wr & (cfg_idx <= spk_pkg::REG_KEY3);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      variant_r <= '0;
      key_r[0]  <= '0;
      key_r[1]  <= '0;
      key_r[2]  <= '0;
      key_r[3]  <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        spk_pkg::REG_VARIANT: variant_r <= pwdata[3:0];
        spk_pkg::REG_KEY0:    key_r[0]  <= pwdata;
        spk_pkg::REG_KEY1:    key_r[1]  <= pwdata;
        spk_pkg::REG_KEY2:    key_r[2]  <= pwdata;
        spk_pkg::REG_KEY3:    key_r[3]  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      spk_pkg::REG_VARIANT: prdata = DW'(variant_r);
      spk_pkg::REG_KEY0:    prdata = key_r[0];
      spk_pkg::REG_KEY1:    prdata = key_r[1];
      spk_pkg::REG_KEY2:    prdata = key_r[2];
      spk_pkg::REG_KEY3:    prdata = key_r[3];
      default:              prdata = '0;
    endcase
  end

  // ---------------- variant parameters ----------------
  spk_pkg::vparam_t vp;
  logic [6:0]       n_bits;
  logic [5:0]       rounds_c;
  logic [RW-1:0]    rounds_last;
  logic [1:0]       lw;
  logic [W-1:0]     mask_w;
  logic [DW-1:0]    mask_d;
  logic [W-1:0]     kw [4];

  assign vp       = spk_pkg::variant_params(variant_r);
  assign n_bits   = (vp.bits > 7'(MAX_WORD_BITS)) ? 7'(MAX_WORD_BITS) : vp.bits;
  assign rounds_c = (vp.rounds > 6'(MAX_ROUNDS)) ? 6'(MAX_ROUNDS) : vp.rounds;
  assign rounds_last = RW'(rounds_c) - RW'(1);
  assign lw       = 2'(vp.words - 3'd1);
  assign mask_w   = {W{1'b1}} >> (7'(W) - n_bits);
  assign mask_d   = {DW{1'b1}} >> (7'(DW) - n_bits);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      kw[i] = key_r[i][W-1:0] & mask_w;
    end
  end

  // ---------------- datapath and sequencer ----------------
  state_t           state_r, state_nxt;
  logic             sched_ok_r, sched_ok_nxt;
  spk_pkg::op_t     op_r, op_nxt;
  logic [W-1:0]     x_r, x_nxt;
  logic [W-1:0]     y_r, y_nxt;
  logic [W-1:0]     k_r, k_nxt;
  logic [W-1:0]     l_r [3];
  logic [W-1:0]     l_nxt [3];
  logic [1:0]       slot_r, slot_nxt;
  logic [RW-1:0]    cnt_r, cnt_nxt;
  logic [AW-1:0]    idx_r, idx_nxt;
  spk_pkg::status_t st_r, st_nxt;
  logic             ov_r, ov_nxt;
  logic [W-1:0]     ox_r, ox_nxt;
  logic [W-1:0]     oy_r, oy_nxt;
  spk_pkg::status_t ost_r, ost_nxt;

  logic             in_acc;
  logic             err_x;
  logic             err_y;

  // RAM and round unit hookup
  logic             ram_we;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [W-1:0]     rk_q;
  spk_pkg::op_t     ru_op;
  logic [W-1:0]     ru_x, ru_y, ru_k;
  logic [W-1:0]     ru_xo, ru_yo;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid & in_ch.ready;
  assign err_x       = |(in_ch.word_x & ~mask_d);
  assign err_y       = |(in_ch.word_y & ~mask_d);

  // the key schedule step is an encrypt round with x = l, y = k, key = i
  always_comb begin
    if (state_r == S_EXPAND) begin
      ru_op = spk_pkg::OP_ENC;
      ru_x  = l_r[slot_r];
      ru_y  = k_r;
      ru_k  = W'(cnt_r);
    end else begin
      ru_op = op_r;
      ru_x  = x_r;
      ru_y  = y_r;
      ru_k  = rk_q;
    end
  end

  spk_round #(.W(W)) u_round (
    .op     (ru_op),
    .n_bits (n_bits),
    .ra     (vp.ra),
    .rb     (vp.rb),
    .x_i    (ru_x),
    .y_i    (ru_y),
    .k_i    (ru_k),
    .x_o    (ru_xo),
    .y_o    (ru_yo)
  );

  spk_ram #(.WIDTH(W), .DEPTH(MAX_ROUNDS)) u_rk_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[AW-1:0]),
    .wdata (k_r),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rk_q)
  );

  always_comb begin
    state_nxt    = state_r;
    sched_ok_nxt = sched_ok_r;
    op_nxt       = op_r;
    x_nxt        = x_r;
    y_nxt        = y_r;
    k_nxt        = k_r;
    l_nxt        = l_r;
    slot_nxt     = slot_r;
    cnt_nxt      = cnt_r;
    idx_nxt      = idx_r;
    st_nxt       = st_r;
    ov_nxt       = ov_r & ~out_ch.ready;
    ox_nxt       = ox_r;
    oy_nxt       = oy_r;
    ost_nxt      = ost_r;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_raddr    = '0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt = spk_pkg::op_t'(in_ch.action);
          x_nxt  = in_ch.word_x[W-1:0];
          y_nxt  = in_ch.word_y[W-1:0];
          st_nxt = spk_pkg::ST_OK;
          if (err_x || err_y) begin
            // oversized word: zero result, no rounds
            x_nxt     = '0;
            y_nxt     = '0;
            st_nxt    = err_x ? spk_pkg::ST_X_BIG : spk_pkg::ST_Y_BIG;
            state_nxt = S_FIN;
          end else if (!sched_ok_r) begin
            cnt_nxt  = '0;
            slot_nxt = '0;
            case (lw)
              2'd1: begin
                l_nxt[0] = kw[0];
                k_nxt    = kw[1];
              end
              2'd2: begin
                l_nxt[0] = kw[1];
                l_nxt[1] = kw[0];
                k_nxt    = kw[2];
              end
              default: begin
                l_nxt[0] = kw[2];
                l_nxt[1] = kw[1];
                l_nxt[2] = kw[0];
                k_nxt    = kw[3];
              end
            endcase
            state_nxt = S_EXPAND;
          end else begin
            state_nxt = S_PREP;
          end
        end
      end

      S_EXPAND: begin
        ram_we = 1'b1;
        if (cnt_r == rounds_last) begin
          sched_ok_nxt = 1'b1;
          state_nxt    = S_PREP;
        end else begin
          l_nxt[slot_r] = ru_xo;
          k_nxt         = ru_yo;
          slot_nxt      = (slot_r + 2'd1 == lw) ? 2'd0 : slot_r + 2'd1;
          cnt_nxt       = cnt_r + RW'(1);
        end
      end

      S_PREP: begin
        // fetch the first round key
        ram_re    = 1'b1;
        ram_raddr = (op_r == spk_pkg::OP_ENC) ? '0 : AW'(rounds_c - 6'd1);
        idx_nxt   = ram_raddr;
        cnt_nxt   = '0;
        state_nxt = S_RUN;
      end

      S_RUN: begin
        x_nxt     = ru_xo;
        y_nxt     = ru_yo;
        cnt_nxt   = cnt_r + RW'(1);
        idx_nxt   = (op_r == spk_pkg::OP_ENC) ? idx_r + AW'(1) : idx_r - AW'(1);
        ram_raddr = idx_nxt;
        if (cnt_r == rounds_last) begin
          state_nxt = S_FIN;
        end else begin
          ram_re = 1'b1;
        end
      end

      S_FIN: begin
        if (!ov_r || out_ch.ready) begin
          ov_nxt    = 1'b1;
          ox_nxt    = x_r;
          oy_nxt    = y_r;
          ost_nxt   = st_r;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // a variant or key write makes the expanded schedule stale
    if (cfg_hit) begin
      sched_ok_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      sched_ok_r <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      sched_ok_r <= sched_ok_nxt;
      ov_r       <= ov_nxt;
    end
    op_r   <= op_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    k_r    <= k_nxt;
    l_r    <= l_nxt;
    slot_r <= slot_nxt;
    cnt_r  <= cnt_nxt;
    idx_r  <= idx_nxt;
    st_r   <= st_nxt;
    ox_r   <= ox_nxt;
    oy_r   <= oy_nxt;
    ost_r  <= ost_nxt;
  end

  assign out_ch.valid  = ov_r;
  assign out_ch.out_x  = DW'(ox_r);
  assign out_ch.out_y  = DW'(oy_r);
  assign out_ch.status = ost_r;

endmodule

[design/spk_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module spk_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 34
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/spk_round.sv]
// Shared Speck round unit: one encrypt or decrypt round at a run-time word size.
// Depends on spk_pkg (op_t). Also drives the key schedule step.
module spk_round #(
  parameter int W = 64
) (
  input  spk_pkg::op_t  op,
  input  logic [6:0]    n_bits,
  input  logic [3:0]    ra,
  input  logic [1:0]    rb,
  input  logic [W-1:0]  x_i,
  input  logic [W-1:0]  y_i,
  input  logic [W-1:0]  k_i,
  output logic [W-1:0]  x_o,
  output logic [W-1:0]  y_o
);

  localparam logic [6:0] WB = 7'(W);

  logic [W-1:0] mask;
  logic [6:0]   ra_w;
  logic [6:0]   rb_w;
  logic [W-1:0] enc_x;
  logic [W-1:0] dec_y;

  function automatic logic [W-1:0] rotr(input logic [W-1:0] v, input logic [6:0] r,
                                         input logic [6:0] n, input logic [W-1:0] m);
    return ((v >> r) | (v << (n - r))) & m;
  endfunction

  function automatic logic [W-1:0] rotl(input logic [W-1:0] v, input logic [6:0] r,
                                         input logic [6:0] n, input logic [W-1:0] m);
    return ((v << r) | (v >> (n - r))) & m;
  endfunction

  assign mask = {W{1'b1}} >> (WB - n_bits);
  assign ra_w = {3'b000, ra};
  assign rb_w = {5'b00000, rb};

  assign enc_x = ((rotr(x_i, ra_w, n_bits, mask) + y_i) & mask) ^ k_i;
  assign dec_y = rotr(y_i ^ x_i, rb_w, n_bits, mask);

  always_comb begin
    case (op)
      spk_pkg::OP_ENC: begin
        x_o = enc_x;
        y_o = rotl(y_i, rb_w, n_bits, mask) ^ enc_x;
      end
      spk_pkg::OP_DEC: begin
        y_o = dec_y;
        x_o = rotl(((x_i ^ k_i) - dec_y) & mask, ra_w, n_bits, mask);
      end
      default: begin
        x_o = x_i;
        y_o = y_i;
      end
    endcase
  end

endmodule
